@@ rtl/ini_text_tokenizer_macros.svh @@
// ----------------------------------------------------------------------------
// ini_text_tokenizer_macros
// Assertion helpers for the INI text tokenizer. Each use expands to one
// labeled concurrent assertion clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INI_TEXT_TOKENIZER_MACROS_SVH
`define INI_TEXT_TOKENIZER_MACROS_SVH

// same-cycle implication
`define INITOK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define INITOK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

// invariant
`define INITOK_ASSERT_ALWAYS(label, cond, msg) \
    `INITOK_ASSERT_NOW(label, 1'b1, cond, msg)

`endif

@@ rtl/initok_pkg.sv @@
// ----------------------------------------------------------------------------
// initok_pkg
// Types, state codes, event codes and character constants shared by the
// INI text tokenizer and its channel interfaces.
// ----------------------------------------------------------------------------
package initok_pkg;

    localparam int MAX_TOKEN   = 256;
    localparam int TOKEN_LEN_W = $clog2(MAX_TOKEN + 1);

    typedef logic [15:0] code_unit_t;
    typedef logic [3:0]  event_kind_t;
    typedef logic [15:0] line_count_t;
    typedef logic [4:0]  parse_state_t;
    typedef logic [TOKEN_LEN_W-1:0] token_len_t;

    // event codes
    localparam event_kind_t EV_NONE       = 4'd0;
    localparam event_kind_t EV_SEC_START  = 4'd1;
    localparam event_kind_t EV_SEC_CHAR   = 4'd2;
    localparam event_kind_t EV_SEC_COMMIT = 4'd3;
    localparam event_kind_t EV_KEY_START  = 4'd4;
    localparam event_kind_t EV_KEY_CHAR   = 4'd5;
    localparam event_kind_t EV_KEY_DONE   = 4'd6;
    localparam event_kind_t EV_VAL_START  = 4'd7;
    localparam event_kind_t EV_VAL_CHAR   = 4'd8;
    localparam event_kind_t EV_VAL_DONE   = 4'd9;

    // parser states
    localparam parse_state_t ST_START         = 5'd1;
    localparam parse_state_t ST_SEC_OPEN      = 5'd2;
    localparam parse_state_t ST_SEC_NAME      = 5'd3;
    localparam parse_state_t ST_SEC_TAIL      = 5'd4;
    localparam parse_state_t ST_SEC_END       = 5'd5;
    localparam parse_state_t ST_LINE          = 5'd6;
    localparam parse_state_t ST_KEY           = 5'd7;
    localparam parse_state_t ST_KEY_TAIL      = 5'd8;
    localparam parse_state_t ST_VAL_PRE       = 5'd9;
    localparam parse_state_t ST_VAL           = 5'd10;
    localparam parse_state_t ST_LINE_AFT_VAL  = 5'd11;
    localparam parse_state_t ST_CMT_AFT_VAL   = 5'd12;
    localparam parse_state_t ST_CMT_AFT_SEC   = 5'd14;
    localparam parse_state_t ST_CMT           = 5'd15;
    localparam parse_state_t ST_LINE_AFT_CMT  = 5'd16;
    localparam parse_state_t ST_SEC_SPACE     = 5'd17;
    localparam parse_state_t ST_HEAD_CMT      = 5'd18;
    localparam parse_state_t ST_ERROR         = 5'd31;

    // characters
    localparam code_unit_t CH_SPACE  = 16'h0020;
    localparam code_unit_t CH_VTAB   = 16'h000B;
    localparam code_unit_t CH_CR     = 16'h000D;
    localparam code_unit_t CH_LF     = 16'h000A;
    localparam code_unit_t CH_UP_A   = 16'h0041;
    localparam code_unit_t CH_UP_Z   = 16'h005A;
    localparam code_unit_t CH_LO_A   = 16'h0061;
    localparam code_unit_t CH_LO_Z   = 16'h007A;
    localparam code_unit_t CH_ZERO   = 16'h0030;
    localparam code_unit_t CH_NINE   = 16'h0039;
    localparam code_unit_t CH_USCORE = 16'h005F;
    localparam code_unit_t CH_LBRACK = 16'h005B;
    localparam code_unit_t CH_RBRACK = 16'h005D;
    localparam code_unit_t CH_SEMI   = 16'h003B;
    localparam code_unit_t CH_EQUAL  = 16'h003D;
    localparam code_unit_t CH_LPAREN = 16'h0028;
    localparam code_unit_t CH_RPAREN = 16'h0029;
    localparam code_unit_t CH_COMMA  = 16'h002C;
    localparam code_unit_t CH_DOT    = 16'h002E;
    localparam code_unit_t CH_BSLASH = 16'h005C;
    localparam code_unit_t CH_COLON  = 16'h003A;
    localparam code_unit_t CH_MINUS  = 16'h002D;

    typedef struct packed {
        event_kind_t event_kind;
        code_unit_t  token_char;
        line_count_t line_number;
        logic        error_flag;
        logic        text_done;
    } token_event_t;

    function automatic logic is_space(input code_unit_t c);
        return (c == CH_SPACE) || (c == CH_VTAB);
    endfunction

    function automatic logic is_name(input code_unit_t c);
        return (c inside {[CH_UP_A:CH_UP_Z]}) || (c inside {[CH_LO_A:CH_LO_Z]}) ||
               (c == CH_USCORE);
    endfunction

    function automatic logic is_digit(input code_unit_t c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_value(input code_unit_t c);
        return is_name(c) || is_digit(c) ||
               (c inside {CH_LPAREN, CH_RPAREN, CH_COMMA, CH_DOT, CH_BSLASH,
                          CH_COLON, CH_MINUS});
    endfunction

endpackage

@@ rtl/initok_text_if.sv @@
// ----------------------------------------------------------------------------
// initok_text_if
// Text request channel: one UTF-16 code unit and an end-of-text mark.
// ----------------------------------------------------------------------------
interface initok_text_if;
    import initok_pkg::*;

    logic       valid;
    logic       ready;
    code_unit_t code_unit;
    logic       end_of_text;

    modport source (output valid, output code_unit, output end_of_text, input ready);
    modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

@@ rtl/initok_event_if.sv @@
// ----------------------------------------------------------------------------
// initok_event_if
// Token event channel: one event per text request.
// ----------------------------------------------------------------------------
interface initok_event_if;
    import initok_pkg::*;

    logic        valid;
    logic        ready;
    event_kind_t event_kind;
    code_unit_t  token_char;
    line_count_t line_number;
    logic        error_flag;
    logic        text_done;

    modport source (output valid, output event_kind, output token_char,
                    output line_number, output error_flag, output text_done,
                    input ready);
    modport sink   (input valid, input event_kind, input token_char,
                    input line_number, input error_flag, input text_done,
                    output ready);
endinterface

@@ rtl/ini_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// ini_text_tokenizer
// Lexer for INI-like text. Each code unit yields one token event with the running
// line count and sticky error flag; all but CR also step the parser state machine.
//
//   channel     dir  fields
//   text_in     in   code_unit[15:0], end_of_text
//   token_out   out  event_kind[3:0], token_char[15:0], line_number[15:0],
//                    error_flag, text_done
//
// One request per cycle unless token_out.ready stalls; the event appears in the cycle after acceptance.
// Each event is held in the single result register.
// rst_n clears parser state, token length, line count and error flag.
// An end-of-text request returns parser state, token length, line count and error flag to their reset values.
// text_in.ready is low only while a held event is stalled by token_out.ready.
// ----------------------------------------------------------------------------
`include "ini_text_tokenizer_macros.svh"

module ini_text_tokenizer
(
    input  logic           clk,
    input  logic           rst_n,
    initok_text_if.sink    text_in,
    initok_event_if.source token_out
);
    import initok_pkg::*;

    parse_state_t state_reg, state_next;
    token_len_t   token_len_reg, token_len_next;
    line_count_t  line_reg, line_next;
    logic         error_reg, error_next;
    logic         out_valid_reg;
    token_event_t result_reg, result_next;

    logic         accept;
    code_unit_t   c;
    logic         skip;
    logic         do_fail;
    logic         do_take;
    logic         do_start;
    logic         do_finish;
    event_kind_t  act_kind;
    parse_state_t act_next;
    token_len_t   len_base;
    line_count_t  line_step;

    logic         end_accept;
    logic         regs_clear;
    logic         out_event;
    logic         out_plain;

    assign text_in.ready = !out_valid_reg || token_out.ready;
    assign accept        = text_in.valid && text_in.ready;

    always_comb
    begin
        c         = text_in.end_of_text ? CH_LF : text_in.code_unit;
        skip      = (text_in.code_unit == CH_CR) && !text_in.end_of_text;
        do_fail   = 1'b0;
        do_take   = 1'b0;
        do_start  = 1'b0;
        do_finish = 1'b0;
        act_kind  = EV_NONE;
        act_next  = state_reg;

        if (!skip)
        begin
            case (state_reg)
                ST_START:
                begin
                    if (is_space(c) || c == CH_LF) act_next = ST_START;
                    else if (c == CH_LBRACK)       act_next = ST_SEC_OPEN;
                    else if (c == CH_SEMI)         act_next = ST_HEAD_CMT;
                    else                           do_fail  = 1'b1;
                end
                ST_SEC_OPEN:
                begin
                    if (is_space(c))
                        act_next = ST_SEC_OPEN;
                    else if (is_name(c))
                    begin
                        do_start = 1'b1;
                        act_kind = EV_SEC_START;
                        act_next = ST_SEC_NAME;
                    end
                    else
                        do_fail = 1'b1;
                end
                ST_SEC_NAME:
                begin
                    if (is_name(c) || is_digit(c))
                    begin
                        do_take  = 1'b1;
                        act_kind = EV_SEC_CHAR;
                        act_next = ST_SEC_NAME;
                    end
                    else if (is_space(c))
                        act_next = ST_SEC_TAIL;
                    else if (c == CH_RBRACK)
                    begin
                        do_finish = 1'b1;
                        act_kind  = EV_SEC_COMMIT;
                        act_next  = ST_SEC_END;
                    end
                    else
                        do_fail = 1'b1;
                end
                ST_SEC_TAIL:
                begin
                    if (is_space(c))
                        act_next = ST_SEC_TAIL;
                    else if (c == CH_RBRACK)
                    begin
                        do_finish = 1'b1;
                        act_kind  = EV_SEC_COMMIT;
                        act_next  = ST_SEC_END;
                    end
                    else
                        do_fail = 1'b1;
                end
                ST_SEC_END:
                begin
                    if (c == CH_LF)          act_next = ST_LINE;
                    else if (is_space(c))    act_next = ST_SEC_SPACE;
                    else if (c == CH_SEMI)   act_next = ST_CMT_AFT_SEC;
                    else                     do_fail  = 1'b1;
                end
                ST_LINE, ST_LINE_AFT_VAL, ST_LINE_AFT_CMT:
                begin
                    if (is_space(c) || c == CH_LF)
                        act_next = ST_LINE;
                    else if (is_name(c))
                    begin
                        do_start = 1'b1;
                        act_kind = EV_KEY_START;
                        act_next = ST_KEY;
                    end
                    else if (c == CH_SEMI)
                        act_next = ST_CMT_AFT_SEC;
                    else if (c == CH_LBRACK)
                        act_next = ST_SEC_OPEN;
                    else
                        do_fail = 1'b1;
                end
                ST_KEY:
                begin
                    if (is_name(c) || is_digit(c))
                    begin
                        do_take  = 1'b1;
                        act_kind = EV_KEY_CHAR;
                        act_next = ST_KEY;
                    end
                    else if (is_space(c))
                        act_next = ST_KEY_TAIL;
                    else if (c == CH_EQUAL)
                    begin
                        do_finish = 1'b1;
                        act_kind  = EV_KEY_DONE;
                        act_next  = ST_VAL_PRE;
                    end
                    else
                        do_fail = 1'b1;
                end
                ST_KEY_TAIL:
                begin
                    if (is_space(c))
                        act_next = ST_KEY_TAIL;
                    else if (c == CH_EQUAL)
                    begin
                        do_finish = 1'b1;
                        act_kind  = EV_KEY_DONE;
                        act_next  = ST_VAL_PRE;
                    end
                    else
                        do_fail = 1'b1;
                end
                ST_VAL_PRE:
                begin
                    if (is_space(c))
                        act_next = ST_VAL_PRE;
                    else if (is_value(c))
                    begin
                        do_start = 1'b1;
                        act_kind = EV_VAL_START;
                        act_next = ST_VAL;
                    end
                    else
                        do_fail = 1'b1;
                end
                ST_VAL:
                begin
                    if (is_space(c) || is_value(c))
                    begin
                        do_take  = 1'b1;
                        act_kind = EV_VAL_CHAR;
                        act_next = ST_VAL;
                    end
                    else if (c == CH_LF)
                    begin
                        do_finish = 1'b1;
                        act_kind  = EV_VAL_DONE;
                        act_next  = ST_LINE_AFT_VAL;
                    end
                    else if (c == CH_SEMI)
                    begin
                        do_finish = 1'b1;
                        act_kind  = EV_VAL_DONE;
                        act_next  = ST_CMT_AFT_VAL;
                    end
                    else
                        do_fail = 1'b1;
                end
                ST_CMT_AFT_VAL, ST_CMT_AFT_SEC, ST_CMT:
                begin
                    act_next = (c == CH_LF) ? ST_LINE_AFT_CMT : ST_CMT;
                end
                ST_SEC_SPACE:
                begin
                    if (is_space(c))         act_next = ST_SEC_SPACE;
                    else if (c == CH_LF)     act_next = ST_LINE;
                    else if (c == CH_SEMI)   act_next = ST_CMT_AFT_SEC;
                    else                     do_fail  = 1'b1;
                end
                ST_HEAD_CMT:
                begin
                    act_next = (c == CH_LF) ? ST_START : ST_HEAD_CMT;
                end
                default:
                begin
                    act_next = state_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        line_step      = line_reg + line_count_t'(1);
        line_next      = (!skip && c == CH_LF) ? line_step : line_reg;
        len_base       = do_start ? '0 : token_len_reg;
        state_next     = act_next;
        token_len_next = token_len_reg;
        error_next     = error_reg || (!skip && state_reg == ST_ERROR);

        result_next.event_kind  = EV_NONE;
        result_next.token_char  = '0;

        if (do_finish)
        begin
            token_len_next         = '0;
            result_next.event_kind = act_kind;
        end
        else if (do_start || do_take)
        begin
            // overlength: the take turns into a failure with no event
            if (len_base >= token_len_t'(MAX_TOKEN))
            begin
                token_len_next = len_base;
                state_next     = ST_ERROR;
                error_next     = 1'b1;
            end
            else
            begin
                token_len_next         = len_base + token_len_t'(1);
                result_next.event_kind = act_kind;
                result_next.token_char = c;
            end
        end

        if (do_fail)
        begin
            state_next = ST_ERROR;
            error_next = 1'b1;
        end

        result_next.line_number = line_next;
        result_next.error_flag  = error_next;
        result_next.text_done   = text_in.end_of_text;

        if (text_in.end_of_text)
        begin
            state_next     = ST_START;
            token_len_next = '0;
            line_next      = '0;
            error_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            token_len_reg <= '0;
            line_reg      <= '0;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                token_len_reg <= token_len_next;
                line_reg      <= line_next;
                error_reg     <= error_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (token_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign token_out.valid       = out_valid_reg;
    assign token_out.event_kind  = result_reg.event_kind;
    assign token_out.token_char  = result_reg.token_char;
    assign token_out.line_number = result_reg.line_number;
    assign token_out.error_flag  = result_reg.error_flag;
    assign token_out.text_done   = result_reg.text_done;

    assign end_accept = accept && text_in.end_of_text;
    assign regs_clear = (state_reg == ST_START) && (token_len_reg == '0) &&
                        (line_reg == '0) && !error_reg;
    assign out_event  = out_valid_reg && (result_reg.event_kind != EV_NONE);
    assign out_plain  = out_valid_reg &&
                        (result_reg.event_kind inside {EV_NONE, EV_SEC_COMMIT,
                                                       EV_KEY_DONE, EV_VAL_DONE});

    `INITOK_ASSERT_ALWAYS(a_len_bound, token_len_reg <= token_len_t'(MAX_TOKEN), "token too long")
    `INITOK_ASSERT_ALWAYS(a_err_state, state_reg != ST_ERROR || error_reg, "error state, flag low")
    `INITOK_ASSERT_NEXT(a_end_reset, end_accept, regs_clear, "end of text did not reset state")
    `INITOK_ASSERT_NOW(a_event_no_err, out_event, !result_reg.error_flag, "event after error")
    `INITOK_ASSERT_NOW(a_char_kind, out_plain, result_reg.token_char == '0, "char on plain event")

endmodule
